>>> hw/rtl/pru_pkg.sv
// Shared constants, types and the Paeth predictor for the PNG row unfilter.
`timescale 1ns / 1ps
`default_nettype none

package pru_pkg;

    // Default sizing of the line store and the pixel history
    localparam int DEF_MAX_ROW_BYTES   = 8192;
    localparam int DEF_MAX_PIXEL_BYTES = 8;

    // Configuration port
    localparam int PADDR_W       = 3;
    localparam int PDATA_W       = 32;
    localparam int ROW_BYTES_W   = 14;
    localparam int PIXEL_BYTES_W = 4;

    localparam logic REG_ROW_BYTES   = 1'b0;
    localparam logic REG_PIXEL_BYTES = 1'b1;

    localparam logic [ROW_BYTES_W-1:0]   ROW_BYTES_RST   = ROW_BYTES_W'(1);
    localparam logic [PIXEL_BYTES_W-1:0] PIXEL_BYTES_RST = PIXEL_BYTES_W'(1);

    // Filter types
    typedef logic [2:0] t_filter;

    localparam t_filter FLT_NONE  = 3'd0;
    localparam t_filter FLT_SUB   = 3'd1;
    localparam t_filter FLT_UP    = 3'd2;
    localparam t_filter FLT_AVG   = 3'd3;
    localparam t_filter FLT_PAETH = 3'd4;

    // Paeth predictor: pick the neighbor closest to a + b - c
    function automatic logic [7:0] paeth(input logic [7:0] a, input logic [7:0] b,
                                         input logic [7:0] c);
        logic signed [9:0] d_pa;
        logic signed [9:0] d_pb;
        logic signed [9:0] d_pc;
        logic [9:0]        pa;
        logic [9:0]        pb;
        logic [9:0]        pc;
        d_pa = $signed({2'b00, b}) - $signed({2'b00, c});
        d_pb = $signed({2'b00, a}) - $signed({2'b00, c});
        d_pc = d_pa + d_pb;
        pa   = d_pa[9] ? 10'(-d_pa) : 10'(d_pa);
        pb   = d_pb[9] ? 10'(-d_pb) : 10'(d_pb);
        pc   = d_pc[9] ? 10'(-d_pc) : 10'(d_pc);
        if (pa <= pb && pa <= pc) begin
            return a;
        end else if (pb <= pc) begin
            return b;
        end else begin
            return c;
        end
    endfunction

endpackage

`default_nettype wire

>>> hw/rtl/png_row_unfilter.sv
// PNG scanline filter reconstruction: line store, predictors and APB register file.
//
// Usage:
//   Feed the inflated PNG stream one byte per transaction on the input channel
//   (i_in_valid / o_in_ready, i_in_byte, i_image_start). A scanline opens with a
//   filter-type byte, which yields no output transaction; each data byte after it
//   yields one (o_out_valid / i_out_ready, o_out_byte, o_row_last). Raise
//   i_image_start with the filter byte of an image's first row; drop any open row.
// Pipeline and throughput:
//   The accept edge reads the line store and registers the byte in the rebuild stage;
//   the rebuild stage registers the rebuilt byte once the output register is free. One
//   byte per cycle without output stalls; the store is read and written once per byte.
// Stalls:
//   The output register holds a finished byte while the receiver stalls; the input
//   accepts one more byte into the rebuild stage, then o_in_ready drops until the
//   output transaction completes.
// Reset:
//   Clears control state; line length and pixel size reset to 1. The line store is
//   not cleared: an image's first row reads zeros above it, so bytes are taken at once.
// Configure the line length (address 0) and pixel size (address 4) only while idle.
`timescale 1ns / 1ps
`default_nettype none

module png_row_unfilter #(
    parameter int MAX_ROW_BYTES   = pru_pkg::DEF_MAX_ROW_BYTES,
    parameter int MAX_PIXEL_BYTES = pru_pkg::DEF_MAX_PIXEL_BYTES
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    // APB-style configuration port
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [pru_pkg::PADDR_W-1:0]  paddr,
    input  wire logic [pru_pkg::PDATA_W-1:0]  pwdata,
    output logic      [pru_pkg::PDATA_W-1:0]  prdata,
    output logic                              pready,
    // Input channel
    input  wire logic                         i_in_valid,
    output logic                              o_in_ready,
    input  wire logic [7:0]                   i_in_byte,
    input  wire logic                         i_image_start,
    // Output channel
    output logic                              o_out_valid,
    input  wire logic                         i_out_ready,
    output logic      [7:0]                   o_out_byte,
    output logic                              o_row_last
);

    localparam int COL_W     = $clog2(MAX_ROW_BYTES);
    localparam int LEN_W     = $clog2(MAX_ROW_BYTES + 1);
    localparam int CW        = (LEN_W > pru_pkg::ROW_BYTES_W) ? LEN_W : pru_pkg::ROW_BYTES_W;
    localparam int PIX_IDX_W = (MAX_PIXEL_BYTES > 1) ? $clog2(MAX_PIXEL_BYTES) : 1;

    // ------------------------------------------------------------------
    // Register file
    // ------------------------------------------------------------------
    logic [pru_pkg::ROW_BYTES_W-1:0]   r_line_len;
    logic [pru_pkg::PIXEL_BYTES_W-1:0] r_pixel_bytes;
    logic                              cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_len    <= pru_pkg::ROW_BYTES_RST;
            r_pixel_bytes <= pru_pkg::PIXEL_BYTES_RST;
        end else if (cfg_wr) begin
            unique case (paddr[2])
                pru_pkg::REG_ROW_BYTES: begin
                    r_line_len <= pwdata[pru_pkg::ROW_BYTES_W-1:0];
                end
                pru_pkg::REG_PIXEL_BYTES: begin
                    r_pixel_bytes <= pwdata[pru_pkg::PIXEL_BYTES_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            pru_pkg::REG_ROW_BYTES:   prdata = pru_pkg::PDATA_W'(r_line_len);
            pru_pkg::REG_PIXEL_BYTES: prdata = pru_pkg::PDATA_W'(r_pixel_bytes);
            default:                  prdata = '0;
        endcase
    end

    // Effective row length and pixel size (zero acts as one, saturate at max)
    logic [CW-1:0]                     eff_len;
    logic [pru_pkg::PIXEL_BYTES_W-1:0] eff_pix;
    logic [pru_pkg::PIXEL_BYTES_W-1:0] eff_pix_m1;

    always_comb begin
        if (r_line_len == '0) begin
            eff_len = CW'(1);
        end else if (CW'(r_line_len) > CW'(MAX_ROW_BYTES)) begin
            eff_len = CW'(MAX_ROW_BYTES);
        end else begin
            eff_len = CW'(r_line_len);
        end
        if (r_pixel_bytes == '0) begin
            eff_pix = pru_pkg::PIXEL_BYTES_W'(1);
        end else if (r_pixel_bytes > pru_pkg::PIXEL_BYTES_W'(MAX_PIXEL_BYTES)) begin
            eff_pix = pru_pkg::PIXEL_BYTES_W'(MAX_PIXEL_BYTES);
        end else begin
            eff_pix = r_pixel_bytes;
        end
        eff_pix_m1 = eff_pix - pru_pkg::PIXEL_BYTES_W'(1);
    end

    // ------------------------------------------------------------------
    // Accept stage: row sequencing and line store read
    // ------------------------------------------------------------------
    logic                 r_await;
    logic                 r_first;
    logic [COL_W-1:0]     r_col;
    pru_pkg::t_filter     r_mode;

    logic                 r_s1_vld;
    logic [7:0]           r_s1_byte;
    logic [COL_W-1:0]     r_s1_col;
    pru_pkg::t_filter     r_s1_mode;
    logic                 r_s1_first;
    logic                 r_s1_inner;
    logic [PIX_IDX_W-1:0] r_s1_pix;
    logic                 r_s1_last;

    logic                 r_out_vld;
    logic [7:0]           r_out_byte;
    logic                 r_out_last;

    logic                 s1_adv;
    logic                 in_acc;
    logic                 await_now;
    logic                 first_now;
    logic                 data_acc;
    logic                 col_last;

    assign s1_adv     = r_s1_vld & (~r_out_vld | i_out_ready);
    assign o_in_ready = ~r_s1_vld | s1_adv;
    assign in_acc     = i_in_valid & o_in_ready;
    assign await_now  = r_await | i_image_start;
    assign first_now  = r_first | i_image_start;
    assign data_acc   = in_acc & ~await_now;
    assign col_last   = (CW'(r_col) + CW'(1)) >= eff_len;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_await <= 1'b1;
            r_first <= 1'b1;
            r_col   <= '0;
            r_mode  <= pru_pkg::FLT_NONE;
        end else if (in_acc) begin
            if (await_now) begin
                // Filter-type byte: latch the predictor, unknown types act as None
                r_mode  <= (i_in_byte <= 8'(pru_pkg::FLT_PAETH))
                           ? pru_pkg::t_filter'(i_in_byte) : pru_pkg::FLT_NONE;
                r_await <= 1'b0;
                r_first <= first_now;
                r_col   <= '0;
            end else if (col_last) begin
                r_col   <= '0;
                r_await <= 1'b1;
                r_first <= 1'b0;
            end else begin
                r_col   <= r_col + COL_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (o_in_ready) begin
            r_s1_vld <= data_acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (data_acc) begin
            r_s1_byte  <= i_in_byte;
            r_s1_col   <= r_col;
            r_s1_mode  <= r_mode;
            r_s1_first <= r_first;
            r_s1_inner <= CW'(r_col) >= CW'(eff_pix);
            r_s1_pix   <= eff_pix_m1[PIX_IDX_W-1:0];
            r_s1_last  <= col_last;
        end
    end

    // Line store: read at accept, written back with the rebuilt byte as it
    // leaves the rebuild stage. The same column is never read and written at one edge:
    // a filter byte always separates a row from the next.
    logic [7:0] prior_row_store [MAX_ROW_BYTES];
    logic [7:0] r_rd_data;
    logic [7:0] res;

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            prior_row_store[r_s1_col] <= res;
        end
        if (data_acc) begin
            r_rd_data <= prior_row_store[r_col];
        end
    end

    // ------------------------------------------------------------------
    // Rebuild stage
    // ------------------------------------------------------------------
    logic [7:0] r_left_hist [MAX_PIXEL_BYTES];
    logic [7:0] r_ul_hist   [MAX_PIXEL_BYTES];
    logic [7:0] nb_a;
    logic [7:0] nb_b;
    logic [7:0] nb_c;
    logic [8:0] avg_sum;
    logic [7:0] pred;

    always_comb begin
        nb_b    = r_s1_first ? 8'd0 : r_rd_data;
        nb_a    = r_s1_inner ? r_left_hist[r_s1_pix] : 8'd0;
        nb_c    = r_s1_inner ? r_ul_hist[r_s1_pix] : 8'd0;
        avg_sum = {1'b0, nb_a} + {1'b0, nb_b};
        case (r_s1_mode)
            pru_pkg::FLT_SUB:   pred = nb_a;
            pru_pkg::FLT_UP:    pred = nb_b;
            pru_pkg::FLT_AVG:   pred = avg_sum[8:1];
            pru_pkg::FLT_PAETH: pred = pru_pkg::paeth(nb_a, nb_b, nb_c);
            default:            pred = 8'd0;
        endcase
        res = r_s1_byte + pred;
    end

    // Advance the pixel histories by one byte per rebuilt byte
    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            for (int i = MAX_PIXEL_BYTES - 1; i > 0; i--) begin
                r_left_hist[i] <= r_left_hist[i-1];
                r_ul_hist[i]   <= r_ul_hist[i-1];
            end
            r_left_hist[0] <= res;
            r_ul_hist[0]   <= nb_b;
        end
    end

    // ------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (s1_adv) begin
            r_out_vld <= 1'b1;
        end else if (i_out_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_out_byte <= res;
            r_out_last <= r_s1_last;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_byte  = r_out_byte;
    assign o_row_last  = r_out_last;

endmodule

`default_nettype wire
